/* rtl/core/abn_pkg.sv */
`timescale 1ns / 1ps

package abn_pkg;

   // Width of the reported divisor sum and its saturation value.
   localparam int unsigned SUM_WIDTH = 27;
   localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_ACCUM,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture a new value and restart the trial divisor
      logic div_start;  // set up a division of the value by the trial divisor
      logic div_step;   // one quotient bit
      logic accum;      // add divisor and cofactor if the division was exact, advance the trial divisor
      logic out_load;   // write the result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic loop_done;  // square of the trial divisor exceeds the value
      logic div_last;   // the current division step is the final one
   } status_type;

endpackage

/* rtl/core/abn_ctrl.sv */
`timescale 1ns / 1ps

module abn_ctrl
   import abn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a new result once the old one is gone.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.loop_done ? ST_FINISH : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            state_in = ST_CHECK;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_CHECK: begin
            cmd.div_start = !status.loop_done;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
         end
         ST_FINISH: begin
            cmd.out_load = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/core/abn_datapath.sv */
`timescale 1ns / 1ps

module abn_datapath
   import abn_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = 24
) (
   input  logic                   clock,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  cmd_type                cmd,
   output status_type             status,
   output logic                   rsp_is_abundant,
   output logic [SUM_WIDTH-1:0]   rsp_divisor_sum
);

   // The trial divisor stops one past the integer square root of the value.
   localparam int unsigned DW = (VALUE_WIDTH + 1) / 2 + 1;
   localparam int unsigned SW = 2 * DW;
   // The proper divisor sum stays below sixteen times the value in this range.
   localparam int unsigned AW = VALUE_WIDTH + 4;
   localparam int unsigned CW = $clog2(VALUE_WIDTH);
   localparam int unsigned EW = (AW > SUM_WIDTH) ? AW : SUM_WIDTH;

   logic [VALUE_WIDTH-1:0] n_ff, n_in;
   logic [DW-1:0]          d_ff, d_in;
   logic [SW-1:0]          sq_ff, sq_in;
   logic [AW-1:0]          acc_ff, acc_in;
   logic [DW-1:0]          rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   abundant_ff, abundant_in;
   logic [SUM_WIDTH-1:0]   sum_ff, sum_in;

   logic [DW:0]            trial;
   logic                   trial_ge;
   logic [DW:0]            trial_diff;
   logic                   add_cofactor;
   logic [AW-1:0]          addend;
   logic [EW-1:0]          acc_ext;

   // Restoring division, one quotient bit per cycle.
   assign trial      = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign trial_ge   = trial >= {1'b0, d_ff};
   assign trial_diff = trial - {1'b0, d_ff};

   assign add_cofactor = (d_ff != DW'(1)) && (quo_ff != VALUE_WIDTH'(d_ff));
   assign addend       = AW'(d_ff) + (add_cofactor ? AW'(quo_ff) : AW'(0));
   assign acc_ext      = EW'(acc_ff);

   assign status.loop_done = sq_ff > SW'(n_ff);
   assign status.div_last  = cnt_ff == '0;

   always_comb begin
      n_in        = n_ff;
      d_in        = d_ff;
      sq_in       = sq_ff;
      acc_in      = acc_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      cnt_in      = cnt_ff;
      abundant_in = abundant_ff;
      sum_in      = sum_ff;
      if (cmd.load) begin
         n_in   = req_value;
         d_in   = DW'(1);
         sq_in  = SW'(1);
         acc_in = '0;
      end
      if (cmd.div_start) begin
         rem_in = '0;
         quo_in = n_ff;
         cnt_in = CW'(VALUE_WIDTH - 1);
      end
      if (cmd.div_step) begin
         rem_in = trial_ge ? trial_diff[DW-1:0] : trial[DW-1:0];
         quo_in = {quo_ff[VALUE_WIDTH-2:0], trial_ge};
         cnt_in = cnt_ff - CW'(1);
      end
      if (cmd.accum) begin
         if (rem_ff == '0) acc_in = acc_ff + addend;
         d_in  = d_ff + DW'(1);
         sq_in = sq_ff + SW'({d_ff, 1'b1});
      end
      if (cmd.out_load) begin
         abundant_in = acc_ff > AW'(n_ff);
         sum_in      = (acc_ext > EW'(SUM_MAX)) ? SUM_MAX : acc_ext[SUM_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      d_ff        <= d_in;
      sq_ff       <= sq_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      abundant_ff <= abundant_in;
      sum_ff      <= sum_in;
   end

   assign rsp_is_abundant = abundant_ff;
   assign rsp_divisor_sum = sum_ff;

endmodule

/* rtl/core/abundant_number_test_unit.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// request   in         req_valid, req_stall  req_value (VALUE_WIDTH bits)
// response  out        rsp_valid, rsp_stall  rsp_is_abundant, rsp_divisor_sum (27 bits)
//
// The time one request takes grows with D = floor(sqrt(value)), the number of trial
// divisors; the bit-serial divider, run once for each trial divisor, sets it.
// Reset is synchronous and active high; it clears the controller and the response valid.
// A finished result waits in the output register while the next request is taken;
// that request stalls only at its end if the old result has not been collected.

module abundant_number_test_unit
   import abn_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_is_abundant,
   output logic [SUM_WIDTH-1:0]   rsp_divisor_sum
);

   // The controller sequences trial divisors and division steps; the datapath
   // holds the value, the divider, the running sum and the output register.
   cmd_type    cmd;
   status_type status;

   abn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   abn_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .req_value       (req_value),
      .cmd             (cmd),
      .status          (status),
      .rsp_is_abundant (rsp_is_abundant),
      .rsp_divisor_sum (rsp_divisor_sum)
   );

endmodule

/* rtl/core/abn_checker.sv */
`timescale 1ns / 1ps

module abn_checker
   import abn_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_is_abundant,
   input logic [SUM_WIDTH-1:0] rsp_divisor_sum
);

   // No response is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_is_abundant)
                                 && $stable(rsp_divisor_sum))
      else $error("stalled response changed");

   // The block is busy with a request after taking it.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   // A result cannot appear in the cycle after a request is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("response appeared too early");

   // An abundant value has a divisor sum above one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_abundant |-> rsp_divisor_sum > SUM_WIDTH'(1))
      else $error("abundant flag with too small a sum");

endmodule

bind abundant_number_test_unit abn_checker u_abn_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_is_abundant (rsp_is_abundant),
   .rsp_divisor_sum (rsp_divisor_sum)
);

/* sim/testbench.sv */
`timescale 1ns / 1ps

// Self-checking bench for the abundant number unit. Each request carries one
// value. The bench predicts the sum of its proper divisors and the abundance
// flag, and compares every response with the oldest prediction still pending.
// The request side and the response side both idle at random. One phase runs
// with no idling at all. Another holds the response side off long enough that
// the unit fills up and stalls its request side. Trial division makes large
// values slow, so most requests use small values and only a few use the
// largest ones.

module testbench
   import abn_pkg::*;
;

   localparam int unsigned VALUE_WIDTH = 24;
   localparam int unsigned IDLE_PERCENT = 22;
   // Cycles for which the response side refuses results during the pressure test.
   localparam int unsigned LONG_HOLD_CYCLES = 1500;
   // Cycles allowed after the last response in case the unit sends more.
   localparam int unsigned SETTLE_CYCLES = 200;
   // A correct run takes at most about 5 ms. This limit is several times that.
   localparam longint unsigned RUN_LIMIT_NS = 40_000_000;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic                   is_abundant;
      logic [SUM_WIDTH-1:0]   divisor_sum;
   } classification_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [VALUE_WIDTH-1:0] req_value;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_is_abundant;
   logic [SUM_WIDTH-1:0]   rsp_divisor_sum;

   // Predictions for accepted requests, oldest first.
   classification_type pending_classifications[$];
   int unsigned        mismatch_count;

   // Random idling switches. The main sequence turns them off for one phase.
   logic sender_idling;
   logic receiver_idling;

   // The main sequence bumps hold_requests to ask for one long hold.
   // The response side counts the holds it has already carried out.
   int unsigned hold_requests;
   int unsigned holds_served;

   abundant_number_test_unit #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_abundant(rsp_is_abundant),
      .rsp_divisor_sum(rsp_divisor_sum)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Sums the proper divisors of a value by trial division. Each divisor d up to
   // the square root adds itself. For d above one it also adds the cofactor,
   // unless the cofactor is d again, as happens for perfect squares. The sum is
   // reported saturated, but the flag is decided on the full sum.
   function automatic classification_type classify_value(
      input logic [VALUE_WIDTH-1:0] value);
      classification_type result;
      longint unsigned    n;
      longint unsigned    total;
      longint unsigned    d;
      longint unsigned    cofactor;
      n = 64'(value);
      total = 0;
      for (d = 1; d * d <= n; d++) begin
         if (n % d == 0) begin
            cofactor = n / d;
            total += d;
            if (d != 1 && cofactor != d) begin
               total += cofactor;
            end
         end
      end
      result.value = value;
      result.is_abundant = (total > n);
      result.divisor_sum = (total > SUM_MAX) ? SUM_MAX : total[SUM_WIDTH-1:0];
      return result;
   endfunction

   // Picks a random value whose size depends on its slot in the sequence, so
   // that the run time stays bounded: most values are small, every twentieth one is
   // large and each remaining fifth one is medium.
   function automatic logic [VALUE_WIDTH-1:0] pick_value(input int unsigned slot);
      logic [VALUE_WIDTH-1:0] value;
      if (slot % 20 == 19) begin
         value = VALUE_WIDTH'($urandom_range(1048575, 65536));
      end else if (slot % 5 == 4) begin
         value = VALUE_WIDTH'($urandom_range(65535, 4096));
      end else begin
         value = VALUE_WIDTH'($urandom_range(4095, 1));
      end
      return value;
   endfunction

   // Offers one request and waits until the unit accepts it. Valid stays high
   // on return, so a following request can go out on the very next cycle.
   task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
      while (sender_idling && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      pending_classifications.push_back(classify_value(value));
   endtask

   // Stops offering requests and waits for every pending response.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (pending_classifications.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Zero, one, primes, perfect numbers, abundant numbers (odd and even),
   // perfect squares where the cofactor equals the divisor, and the all-ones
   // value with the slowest search of all.
   task automatic test_directed_values();
      send_value(0);
      send_value(1);
      send_value(2);
      send_value(7);
      send_value(6);
      send_value(12);
      send_value(16);
      send_value(36);
      send_value(28);
      send_value(945);
      send_value(496);
      send_value(8128);
      send_value(4095);
      send_value(4096);
      send_value(720720);
      send_value({VALUE_WIDTH{1'b1}});
      wait_for_responses();
   endtask

   // The main random stream, with idling on both sides.
   task automatic test_random_values(input int unsigned count);
      int unsigned slot;
      for (slot = 0; slot < count; slot++) begin
         send_value(pick_value(slot));
      end
      wait_for_responses();
   endtask

   // Requests go out on every cycle the unit does not stall and results are taken on every cycle.
   task automatic test_back_to_back();
      int unsigned slot;
      sender_idling = 1'b0;
      receiver_idling = 1'b0;
      for (slot = 0; slot < 12; slot++) begin
         send_value(VALUE_WIDTH'($urandom_range(300, 1)));
      end
      wait_for_responses();
      sender_idling = 1'b1;
      receiver_idling = 1'b1;
   endtask

   // The response side holds off while short requests keep coming. The unit
   // parks one result, finishes the next one and must then stall its request
   // side until the hold ends.
   task automatic test_response_hold();
      int unsigned slot;
      hold_requests++;
      for (slot = 0; slot < 6; slot++) begin
         send_value(VALUE_WIDTH'($urandom_range(40, 1)));
      end
      wait_for_responses();
   endtask

   // A burst, a full pause until the unit has drained, then another burst.
   task automatic test_pause_and_resume();
      int unsigned slot;
      for (slot = 0; slot < 4; slot++) begin
         send_value(VALUE_WIDTH'($urandom_range(2000, 1)));
      end
      wait_for_responses();
      for (slot = 0; slot < 4; slot++) begin
         send_value(VALUE_WIDTH'($urandom_range(2000, 1)));
      end
      wait_for_responses();
   endtask

   // Response side: random stalls, or a long hold when one has been asked for.
   initial begin : response_side
      int unsigned hold_left;
      hold_left = 0;
      holds_served = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (receiver_idling) begin
            rsp_stall <= ($urandom_range(99) < IDLE_PERCENT);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every accepted response is compared with the oldest prediction.
   always @(posedge clock) begin
      classification_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_classifications.size() == 0) begin
            $display("%0t: response with nothing pending: is_abundant %0b divisor_sum %0d",
                     $time, rsp_is_abundant, rsp_divisor_sum);
            mismatch_count++;
         end else begin
            want = pending_classifications.pop_front();
            if (rsp_is_abundant !== want.is_abundant) begin
               $display("%0t: value %0d is_abundant expected %0b actual %0b",
                        $time, want.value, want.is_abundant, rsp_is_abundant);
               mismatch_count++;
            end
            if (rsp_divisor_sum !== want.divisor_sum) begin
               $display("%0t: value %0d divisor_sum expected %0d actual %0d",
                        $time, want.value, want.divisor_sum, rsp_divisor_sum);
               mismatch_count++;
            end
         end
      end
   end

   // The whole run ends here if the unit hangs.
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : main_sequence
      reset = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      mismatch_count = 0;
      hold_requests = 0;
      sender_idling = 1'b1;
      receiver_idling = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_values();
      test_back_to_back();
      test_response_hold();
      test_random_values(60);
      test_pause_and_resume();

      // Give the unit time to show any response that nobody asked for.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_classifications.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
